/* hw/rtl/b64gc_pkg.sv */
// b64gc_pkg: shared types, codes and the sextet-to-character map for the
// base64 group codec. No dependencies.

package b64gc_pkg;

  // operation select carried on the mode input
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // decoded view of one character
  typedef struct packed {
    logic [5:0] val;  // sextet value, zero when outside the alphabet
    logic       bad;  // not a member of the alphabet
    logic       pad;  // the pad character
  } char_info_t;

  // standard alphabet lookup
  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] c;
    c = 8'h2F;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end
    return c;
  endfunction

endpackage

/* hw/rtl/b64gc_char_dec.sv */
// b64gc_char_dec: maps one character to its sextet value with alphabet and
// pad flags. Depends on b64gc_pkg.

module b64gc_char_dec (
  input  logic [7:0]             char_i,
  output b64gc_pkg::char_info_t  info_o
);

  always_comb begin
    info_o.val = 6'd0;
    info_o.bad = 1'b0;
    info_o.pad = (char_i == b64gc_pkg::PAD_CHAR);
    priority if (char_i >= 8'h41 && char_i <= 8'h5A) begin
      info_o.val = 6'(char_i - 8'h41);
    end else if (char_i >= 8'h61 && char_i <= 8'h7A) begin
      info_o.val = 6'(char_i - 8'h61 + 8'd26);
    end else if (char_i >= 8'h30 && char_i <= 8'h39) begin
      info_o.val = 6'(char_i - 8'h30 + 8'd52);
    end else if (char_i == 8'h2B) begin
      info_o.val = 6'd62;
    end else if (char_i == 8'h2F) begin
      info_o.val = 6'd63;
    end else begin
      info_o.bad = 1'b1;
    end
  end

endmodule

/* hw/rtl/base64_group_codec.sv */
// base64_group_codec: three-stage pipelined base64 group encoder/decoder.
// Depends on b64gc_pkg and b64gc_char_dec.
//
//   channel   | ports                                         | flow
//   ----------+-----------------------------------------------+------------------
//   request   | start_i, busy_o, mode_i, byte_count_i,        | in, start & !busy
//             | in_byte0_i .. in_byte3_i                      |
//   result    | valid_o, out_byte0_o .. out_byte3_o,          | out, one-cycle
//             | out_count_o, bad_char_o                       | strobe
//
// one request per cycle; the result strobe follows acceptance through the stage a, stage b and output registers
// stages: input capture, sextet split / character decode, alphabet map and
// byte assembly into the output registers
// rst_ni clears the stage valid bits only; payload registers are not reset
// the receiver cannot stall, so the pipeline never holds and busy_o stays low

module base64_group_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       mode_i,
  input  logic [1:0] byte_count_i,
  input  logic [7:0] in_byte0_i,
  input  logic [7:0] in_byte1_i,
  input  logic [7:0] in_byte2_i,
  input  logic [7:0] in_byte3_i,
  output logic       valid_o,
  output logic [7:0] out_byte0_o,
  output logic [7:0] out_byte1_o,
  output logic [7:0] out_byte2_o,
  output logic [7:0] out_byte3_o,
  output logic [2:0] out_count_o,
  output logic       bad_char_o
);

  // no back pressure anywhere in the pipe
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------- stage a
  // plain capture of the request
  logic                a_valid_q;
  b64gc_pkg::mode_e    a_mode_q;
  logic [1:0]          a_cnt_q;
  logic [3:0][7:0]     a_byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mode_q <= b64gc_pkg::mode_e'(mode_i);
    a_cnt_q  <= byte_count_i;
    a_byte_q <= {in_byte3_i, in_byte2_i, in_byte1_i, in_byte0_i};
  end

  // ---------------------------------------------------------------- stage b
  // encode: split the gated bytes into four sextets, mark pad positions
  // decode: look each character up in the alphabet
  b64gc_pkg::char_info_t [3:0] dec_info;

  for (genvar k = 0; k < 4; k++) begin : g_dec
    b64gc_char_dec u_char_dec (
      .char_i (a_byte_q[k]),
      .info_o (dec_info[k])
    );
  end

  logic [7:0]      enc_g1, enc_g2;
  logic [3:0][5:0] b_sext_d;
  logic [3:0]      b_bad_d, b_pad_d;
  logic            b_zero_d;

  always_comb begin
    enc_g1   = (a_cnt_q > 2'd1) ? a_byte_q[1] : 8'd0;
    enc_g2   = (a_cnt_q > 2'd2) ? a_byte_q[2] : 8'd0;
    b_zero_d = 1'b0;
    unique case (a_mode_q)
      b64gc_pkg::MODE_ENCODE: begin
        b_sext_d[0] = a_byte_q[0][7:2];
        b_sext_d[1] = {a_byte_q[0][1:0], enc_g1[7:4]};
        b_sext_d[2] = {enc_g1[3:0], enc_g2[7:6]};
        b_sext_d[3] = enc_g2[5:0];
        b_bad_d     = 4'b0000;
        // missing positions are filled with the pad character
        b_pad_d     = {a_cnt_q < 2'd3, a_cnt_q < 2'd2, 2'b00};
        b_zero_d    = (a_cnt_q == 2'd0);
      end
      b64gc_pkg::MODE_DECODE: begin
        for (int k = 0; k < 4; k++) begin
          b_sext_d[k] = dec_info[k].val;
          b_bad_d[k]  = dec_info[k].bad;
          b_pad_d[k]  = dec_info[k].pad;
        end
      end
      default: begin
        b_sext_d = '0;
        b_bad_d  = '0;
        b_pad_d  = '0;
      end
    endcase
  end

  logic                b_valid_q;
  b64gc_pkg::mode_e    b_mode_q;
  logic [3:0][5:0]     b_sext_q;
  logic [3:0]          b_bad_q, b_pad_q;
  logic                b_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_mode_q <= a_mode_q;
    b_sext_q <= b_sext_d;
    b_bad_q  <= b_bad_d;
    b_pad_q  <= b_pad_d;
    b_zero_q <= b_zero_d;
  end

  // ---------------------------------------------------------------- stage c
  // encode: alphabet map; decode: byte assembly, stop at pad in 0, 2 or 3
  logic [3:0][7:0] c_byte_d;
  logic [2:0]      c_count_d;
  logic            c_bad_d;

  always_comb begin
    c_byte_d  = '0;
    c_count_d = 3'd0;
    c_bad_d   = 1'b0;
    unique case (b_mode_q)
      b64gc_pkg::MODE_ENCODE: begin
        if (!b_zero_q) begin
          for (int k = 0; k < 4; k++) begin
            c_byte_d[k] = b_pad_q[k] ? b64gc_pkg::PAD_CHAR
                                     : b64gc_pkg::enc_char(b_sext_q[k]);
          end
          c_count_d = 3'd4;
        end
      end
      b64gc_pkg::MODE_DECODE: begin
        if (!b_pad_q[0]) begin
          // a pad in position 1 is just an out-of-alphabet character
          c_byte_d[0] = {b_sext_q[0], b_sext_q[1][5:4]};
          c_count_d   = 3'd1;
          c_bad_d     = b_bad_q[0] | b_bad_q[1];
          if (!b_pad_q[2]) begin
            c_byte_d[1] = {b_sext_q[1][3:0], b_sext_q[2][5:2]};
            c_count_d   = 3'd2;
            c_bad_d     = c_bad_d | b_bad_q[2];
            if (!b_pad_q[3]) begin
              c_byte_d[2] = {b_sext_q[2][1:0], b_sext_q[3]};
              c_count_d   = 3'd3;
              c_bad_d     = c_bad_d | b_bad_q[3];
            end
          end
        end
      end
      default: begin
        c_byte_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte0_o <= c_byte_d[0];
    out_byte1_o <= c_byte_d[1];
    out_byte2_o <= c_byte_d[2];
    out_byte3_o <= c_byte_d[3];
    out_count_o <= c_count_d;
    bad_char_o  <= c_bad_d;
  end

  // ---------------------------------------------------------------- checks
  a_valid_travels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |=> valid_o)
    else $error("stage b request lost before the output");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_valid_q |=> !valid_o)
    else $error("result strobe without a request behind it");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> out_count_o <= 3'd4)
    else $error("result count out of range");

  a_encode_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_count_o == 3'd4 |-> !bad_char_o)
    else $error("bad character flagged on an encode result");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_count_o != 3'd3 && out_count_o != 3'd4 |-> out_byte2_o == 8'd0)
    else $error("unproduced byte not cleared");

endmodule
